>>> sv/tlpte_pkg.sv
package tlpte_pkg;

  localparam int unsigned DIR_ENTRIES = 1024;
  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned TBL_ENTRIES = 1024;

  localparam int unsigned DIR_AW  = $clog2(DIR_ENTRIES);
  localparam int unsigned IDX_W   = $clog2(TBL_ENTRIES);
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned SPARE_W = 4;
  localparam int unsigned SPARE_N = 2 ** SPARE_W;

  localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned TBL_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
  localparam int unsigned TBL_AW    = SLOT_W + IDX_W;

  typedef enum logic [1:0] {
    FUNC_MAP   = 2'd0,
    FUNC_UNMAP = 2'd1,
    FUNC_XLATE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_DIR  = 2'd1,
    STAT_NO_PAGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DIR,
    S_TBL,
    S_CLR,
    S_RESP
  } state_e;

  // Only the bits that any later lookup can observe are stored.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              present;
  } pde_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
  } pte_t;

endpackage

>>> sv/two_level_page_table_engine.sv
// Flow: each word reads the directory; a map into a present directory entry writes the table,
// unmap or translate with a present entry reads the table, and a directory fault or unknown
// operation goes straight to the response; a map into an absent entry links the claimed slot
// and sweeps it clear. The result is then loaded into the output register. A word is taken
// only in idle, so no new word enters before the last is through; a held result stalls the next word.
// Reset: a pass writes the directory and slot 0 identity map, in_ready_o low.
module two_level_page_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] virt_addr_i,
  input  logic [19:0] phys_frame_i,
  input  logic [11:0] flags_i,
  input  logic [3:0]  spare_table_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] xlat_addr_o,
  output logic [1:0]  status_o,
  output logic        table_used_o
);

  localparam int unsigned SlotW  = tlpte_pkg::SLOT_W;
  localparam int unsigned IdxW   = tlpte_pkg::IDX_W;
  localparam int unsigned DirAw  = tlpte_pkg::DIR_AW;
  localparam int unsigned TblAw  = tlpte_pkg::TBL_AW;
  localparam int unsigned FrameW = tlpte_pkg::FRAME_W;
  localparam int unsigned OffW   = tlpte_pkg::OFF_W;

  tlpte_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;

  // captured word
  tlpte_pkg::func_e  func_q;
  logic [31:0]       va_q;
  logic [FrameW-1:0] frame_q;
  logic              flag_p_q;
  logic [SlotW-1:0]  spare_q;

  // result being built, and the output register
  logic [31:0]         res_phys_q, res_phys_d;
  tlpte_pkg::status_e  res_stat_q, res_stat_d;
  logic                res_used_q, res_used_d;
  logic                out_valid_q;
  logic [31:0]         out_phys_q;
  logic [1:0]          out_stat_q;
  logic                out_used_q;
  logic                load_out;
  logic                accept;

  // memories
  tlpte_pkg::pde_t dir_mem [tlpte_pkg::DIR_ENTRIES];
  tlpte_pkg::pte_t tbl_mem [tlpte_pkg::TBL_DEPTH];
  tlpte_pkg::pde_t dir_rdata_q, dir_wdata;
  tlpte_pkg::pte_t tbl_rdata_q, tbl_wdata;
  logic             dir_re, dir_we, tbl_re, tbl_we;
  logic [DirAw-1:0] dir_raddr, dir_waddr;
  logic [TblAw-1:0] tbl_raddr, tbl_waddr;

  logic [IdxW-1:0]  ti;
  logic [SlotW-1:0] spare_lut [tlpte_pkg::SPARE_N];

  // spare slot number reduced modulo the slot count
  for (genvar g = 0; g < tlpte_pkg::SPARE_N; g++) begin : g_spare
    assign spare_lut[g] = SlotW'(g % tlpte_pkg::TABLE_SLOTS);
  end

  assign ti         = va_q[21:12];
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == tlpte_pkg::S_IDLE);

  assign out_valid_o  = out_valid_q;
  assign xlat_addr_o  = out_phys_q;
  assign status_o     = out_stat_q;
  assign table_used_o = out_used_q;

  always_ff @(posedge clk_i) begin
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    if (dir_re) dir_rdata_q <= dir_mem[dir_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlpte_pkg::S_INIT: begin
        if (cnt_q == IdxW'(tlpte_pkg::TBL_ENTRIES - 1)) state_d = tlpte_pkg::S_IDLE;
      end
      tlpte_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tlpte_pkg::S_DIR;
      end
      tlpte_pkg::S_DIR: begin
        unique case (func_q)
          tlpte_pkg::FUNC_MAP: begin
            state_d = dir_rdata_q.present ? tlpte_pkg::S_RESP : tlpte_pkg::S_CLR;
          end
          tlpte_pkg::FUNC_UNMAP, tlpte_pkg::FUNC_XLATE: begin
            state_d = dir_rdata_q.present ? tlpte_pkg::S_TBL : tlpte_pkg::S_RESP;
          end
          default: state_d = tlpte_pkg::S_RESP;
        endcase
      end
      tlpte_pkg::S_TBL: state_d = tlpte_pkg::S_RESP;
      tlpte_pkg::S_CLR: begin
        if (cnt_q == IdxW'(tlpte_pkg::TBL_ENTRIES - 1)) state_d = tlpte_pkg::S_RESP;
      end
      tlpte_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) state_d = tlpte_pkg::S_IDLE;
      end
      default: state_d = tlpte_pkg::S_INIT;
    endcase
  end

  // memory controls and result
  always_comb begin
    dir_re     = 1'b0;
    dir_raddr  = virt_addr_i[31:22];
    dir_we     = 1'b0;
    dir_waddr  = va_q[31:22];
    dir_wdata  = '0;
    tbl_re     = 1'b0;
    tbl_raddr  = {dir_rdata_q.slot, ti};
    tbl_we     = 1'b0;
    tbl_waddr  = {dir_rdata_q.slot, ti};
    tbl_wdata  = '0;
    res_phys_d = res_phys_q;
    res_stat_d = res_stat_q;
    res_used_d = res_used_q;
    cnt_d      = cnt_q;
    load_out   = 1'b0;
    unique case (state_q)
      tlpte_pkg::S_INIT: begin
        dir_we            = 1'b1;
        dir_waddr         = DirAw'(cnt_q);
        dir_wdata.slot    = '0;
        dir_wdata.present = (cnt_q == '0);
        tbl_we            = 1'b1;
        tbl_waddr         = {SlotW'(0), cnt_q};
        tbl_wdata.frame   = FrameW'(cnt_q);
        tbl_wdata.present = 1'b1;
        cnt_d             = cnt_q + IdxW'(1);
      end
      tlpte_pkg::S_IDLE: begin
        dir_re = in_valid_i;
      end
      tlpte_pkg::S_DIR: begin
        res_phys_d = '0;
        res_stat_d = tlpte_pkg::STAT_OK;
        res_used_d = 1'b0;
        unique case (func_q)
          tlpte_pkg::FUNC_MAP: begin
            if (dir_rdata_q.present) begin
              tbl_we            = 1'b1;
              tbl_wdata.frame   = frame_q;
              tbl_wdata.present = flag_p_q;
            end else begin
              // link the claimed slot, then sweep it
              dir_we            = 1'b1;
              dir_wdata.slot    = spare_q;
              dir_wdata.present = 1'b1;
              res_used_d        = 1'b1;
              cnt_d             = '0;
            end
          end
          tlpte_pkg::FUNC_UNMAP, tlpte_pkg::FUNC_XLATE: begin
            if (dir_rdata_q.present) tbl_re = 1'b1;
            else res_stat_d = tlpte_pkg::STAT_NO_DIR;
          end
          default: ;
        endcase
      end
      tlpte_pkg::S_TBL: begin
        if (!tbl_rdata_q.present) begin
          res_stat_d = tlpte_pkg::STAT_NO_PAGE;
        end else if (func_q == tlpte_pkg::FUNC_UNMAP) begin
          tbl_we = 1'b1;
        end else begin
          res_phys_d = {tbl_rdata_q.frame, va_q[OffW-1:0]};
        end
      end
      tlpte_pkg::S_CLR: begin
        // clear the slot, dropping the new entry in on the way
        tbl_we    = 1'b1;
        tbl_waddr = {spare_q, cnt_q};
        if (cnt_q == ti) begin
          tbl_wdata.frame   = frame_q;
          tbl_wdata.present = flag_p_q;
        end
        cnt_d = cnt_q + IdxW'(1);
      end
      tlpte_pkg::S_RESP: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlpte_pkg::S_INIT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= tlpte_pkg::func_e'(func_i);
      va_q     <= virt_addr_i;
      frame_q  <= phys_frame_i;
      flag_p_q <= flags_i[0];
      spare_q  <= spare_lut[spare_table_i];
    end
    res_phys_q <= res_phys_d;
    res_stat_q <= res_stat_d;
    res_used_q <= res_used_d;
    if (load_out) begin
      out_phys_q <= res_phys_q;
      out_stat_q <= res_stat_q;
      out_used_q <= res_used_q;
    end
  end

  a_clr_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tlpte_pkg::S_CLR |-> tbl_we && tbl_waddr[IdxW-1:0] == cnt_q)
    else $error("slot sweep skipped an entry");

  a_used_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlpte_pkg::S_RESP && res_used_q) |-> func_q == tlpte_pkg::FUNC_MAP)
    else $error("slot claimed by an operation other than map");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tlpte_pkg::S_RESP)
    else $error("result raised outside the response step");

  a_dir_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dir_we && dir_re))
    else $error("directory read and write in the same cycle");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != tlpte_pkg::STAT_OK) |-> xlat_addr_o == '0)
    else $error("faulting word carries a nonzero address");

endmodule
